### design/trd_pkg.sv
`timescale 1ns / 1ps
package trd_pkg;

  localparam int unsigned CHANNELS     = 32;
  localparam int unsigned TRACK_ROWS   = 64;
  localparam int unsigned MAX_PATTERNS = 128;
  localparam int unsigned MAX_TRACKS   = 256;

  localparam int unsigned PAT_DEPTH = MAX_PATTERNS * CHANNELS;
  localparam int unsigned ROW_DEPTH = MAX_TRACKS * TRACK_ROWS;
  localparam int unsigned PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int unsigned ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W     = $clog2(CHANNELS + 1);
  localparam int unsigned PATNUM_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes of the input item
  localparam logic [1:0] OP_PAT_WR = 2'd0;
  localparam logic [1:0] OP_ROW_WR = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_ROWS_PER_PATTERN = 2'd1;
  localparam logic [1:0] CFG_LAST_PATTERN     = 2'd2;
  localparam logic [1:0] CFG_TRACK_COUNT      = 2'd3;

  typedef enum logic [1:0] {
    CMD_PAT_WR,
    CMD_ROW_WR,
    CMD_READ,
    CMD_ERROR
  } trd_cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PAT,
    BK_TRK,
    BK_EMIT
  } trd_state_e;

  typedef struct packed {
    trd_cmd_e              kind;
    logic [13:0]           addr;
    logic [23:0]           value;
    logic [5:0]            row;
    logic [PATNUM_W-1:0]   pat;
  } trd_cmd_t;

  typedef struct packed {
    logic [5:0] channel_count;
    logic [6:0] rows_per_pattern;
    logic [6:0] last_pattern;
    logic [8:0] track_count;
  } trd_cfg_t;

  typedef struct packed {
    logic [4:0]  channel;
    logic [14:0] period;
    logic [5:0]  instrument;
    logic [3:0]  effect;
    logic [7:0]  effect_param;
    logic        last;
    logic        error;
  } trd_res_t;

  function automatic logic [14:0] note_period(input logic [5:0] note);
    logic [2:0]  oct;
    logic [5:0]  semi;
    logic [10:0] base;
    logic [10:0] shifted;
    if (note >= 6'd60) begin
      oct = 3'd5;
    end else if (note >= 6'd48) begin
      oct = 3'd4;
    end else if (note >= 6'd36) begin
      oct = 3'd3;
    end else if (note >= 6'd24) begin
      oct = 3'd2;
    end else if (note >= 6'd12) begin
      oct = 3'd1;
    end else begin
      oct = 3'd0;
    end
    semi = note - ({3'b000, oct} * 6'd12);
    case (semi)
      6'd0:    base = 11'd1712;
      6'd1:    base = 11'd1616;
      6'd2:    base = 11'd1524;
      6'd3:    base = 11'd1440;
      6'd4:    base = 11'd1356;
      6'd5:    base = 11'd1280;
      6'd6:    base = 11'd1208;
      6'd7:    base = 11'd1140;
      6'd8:    base = 11'd1076;
      6'd9:    base = 11'd1016;
      6'd10:   base = 11'd960;
      6'd11:   base = 11'd907;
      default: base = 11'd0;
    endcase
    shifted = base >> oct;
    if (note == 6'd0) begin
      return 15'd0;
    end
    return {shifted, 4'b0000};
  endfunction

endpackage

### design/trd_front.sv
`timescale 1ns / 1ps
module trd_front (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [55:0]        s_axis_tdata_i,
  input  trd_pkg::trd_cfg_t  cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output trd_pkg::trd_cmd_t  cmd_o
);

  logic [1:0]  opcode;
  logic [13:0] slot_address;
  logic [23:0] write_value;
  logic [5:0]  row_number;
  logic [7:0]  pattern_number;
  logic        bad_req;
  logic        keep;

  assign opcode         = s_axis_tdata_i[1:0];
  assign slot_address   = s_axis_tdata_i[15:2];
  assign write_value    = s_axis_tdata_i[39:16];
  assign row_number     = s_axis_tdata_i[45:40];
  assign pattern_number = s_axis_tdata_i[53:46];

  assign bad_req = ({1'b0, row_number} >= cfg_i.rows_per_pattern)
                || (pattern_number > {1'b0, cfg_i.last_pattern})
                || (32'(pattern_number) >= trd_pkg::MAX_PATTERNS)
                || (32'(row_number) >= trd_pkg::TRACK_ROWS);

  always_comb begin
    keep        = 1'b0;
    cmd_o.kind  = trd_pkg::CMD_ERROR;
    cmd_o.addr  = slot_address;
    cmd_o.value = write_value;
    cmd_o.row   = row_number;
    cmd_o.pat   = pattern_number[trd_pkg::PATNUM_W-1:0];
    case (opcode)
      trd_pkg::OP_PAT_WR: begin
        cmd_o.kind = trd_pkg::CMD_PAT_WR;
        keep       = 32'(slot_address) < trd_pkg::PAT_DEPTH;
      end
      trd_pkg::OP_ROW_WR: begin
        cmd_o.kind = trd_pkg::CMD_ROW_WR;
        keep       = 32'(slot_address) < trd_pkg::ROW_DEPTH;
      end
      trd_pkg::OP_READ: begin
        cmd_o.kind = bad_req ? trd_pkg::CMD_ERROR : trd_pkg::CMD_READ;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i && keep;

endmodule

### design/trd_queue.sv
`timescale 1ns / 1ps
module trd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trd_pkg::trd_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output trd_pkg::trd_cmd_t data_o
);

  trd_pkg::trd_cmd_t                  mem_q [trd_pkg::QUEUE_DEPTH];
  logic [trd_pkg::QPTR_W-1:0]         wptr_q, wptr_d;
  logic [trd_pkg::QPTR_W-1:0]         rptr_q, rptr_d;
  logic [trd_pkg::QCNT_W-1:0]         cnt_q, cnt_d;

  assign full_o  = cnt_q == trd_pkg::QCNT_W'(trd_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### design/trd_back.sv
`timescale 1ns / 1ps
module trd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trd_pkg::trd_cfg_t cfg_i,
  input  logic              empty_i,
  input  trd_pkg::trd_cmd_t cmd_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output trd_pkg::trd_res_t res_o
);

  logic [15:0] pat_mem [trd_pkg::PAT_DEPTH];
  logic [23:0] row_mem [trd_pkg::ROW_DEPTH];

  trd_pkg::trd_state_e state_q, state_d;
  logic [trd_pkg::CHAN_W-1:0]   chan_q;
  logic [trd_pkg::CNT_W-1:0]    chans_q;
  logic [trd_pkg::PATNUM_W-1:0] pat_q;
  logic [5:0]                   row_q;
  logic                         blank_q;
  logic [15:0]                  pat_rdata_q;
  logic [23:0]                  row_rdata_q;
  logic                         out_valid_q;
  trd_pkg::trd_res_t            out_q;

  logic                         out_free;
  logic                         is_last;
  logic                         pat_we, row_we, pat_re, row_re;
  logic                         start, load_out, advance;
  logic [trd_pkg::PAT_AW-1:0]   pat_raddr;
  logic [trd_pkg::ROW_AW-1:0]   row_raddr;
  logic [15:0]                  trk_m1;
  logic                         blank;
  logic [trd_pkg::CNT_W-1:0]    chans_clamped;
  logic [23:0]                  bytes;
  trd_pkg::trd_res_t            res_d;

  assign out_free = !out_valid_q || m_ready_i;
  assign is_last  = ({1'b0, chan_q} + 1'b1) == chans_q;

  assign pat_raddr = trd_pkg::PAT_AW'(pat_q) * trd_pkg::PAT_AW'(trd_pkg::CHANNELS)
                   + trd_pkg::PAT_AW'(chan_q);
  assign trk_m1    = pat_rdata_q - 16'd1;
  assign blank     = (pat_rdata_q == 16'd0)
                  || !(trk_m1 < 16'(cfg_i.track_count))
                  || !(32'(trk_m1) < trd_pkg::MAX_TRACKS);
  assign row_raddr = trd_pkg::ROW_AW'(trk_m1) * trd_pkg::ROW_AW'(trd_pkg::TRACK_ROWS)
                   + trd_pkg::ROW_AW'(row_q);

  always_comb begin
    if (cfg_i.channel_count == 6'd0) begin
      chans_clamped = trd_pkg::CNT_W'(1);
    end else if (32'(cfg_i.channel_count) > trd_pkg::CHANNELS) begin
      chans_clamped = trd_pkg::CNT_W'(trd_pkg::CHANNELS);
    end else begin
      chans_clamped = trd_pkg::CNT_W'(cfg_i.channel_count);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      trd_pkg::BK_IDLE: begin
        if (!empty_i && cmd_i.kind == trd_pkg::CMD_READ) begin
          state_d = trd_pkg::BK_PAT;
        end
      end
      trd_pkg::BK_PAT:  state_d = trd_pkg::BK_TRK;
      trd_pkg::BK_TRK:  state_d = trd_pkg::BK_EMIT;
      trd_pkg::BK_EMIT: begin
        if (out_free) begin
          state_d = is_last ? trd_pkg::BK_IDLE : trd_pkg::BK_PAT;
        end
      end
      default: state_d = trd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    pat_we   = 1'b0;
    row_we   = 1'b0;
    pat_re   = 1'b0;
    row_re   = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    advance  = 1'b0;
    bytes    = blank_q ? 24'd0 : row_rdata_q;
    res_d.channel      = 5'(chan_q);
    res_d.period       = trd_pkg::note_period(bytes[23:18]);
    res_d.instrument   = {bytes[17:16], bytes[15:12]};
    res_d.effect       = bytes[11:8];
    res_d.effect_param = bytes[7:0];
    res_d.last         = is_last;
    res_d.error        = 1'b0;
    case (state_q)
      trd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.kind)
            trd_pkg::CMD_PAT_WR: begin
              pop_o  = 1'b1;
              pat_we = 1'b1;
            end
            trd_pkg::CMD_ROW_WR: begin
              pop_o  = 1'b1;
              row_we = 1'b1;
            end
            trd_pkg::CMD_READ: begin
              pop_o = 1'b1;
              start = 1'b1;
            end
            default: begin
              if (out_free) begin
                pop_o    = 1'b1;
                load_out = 1'b1;
                res_d    = '{channel: 5'd0, period: 15'd0, instrument: 6'd0,
                             effect: 4'd0, effect_param: 8'd0, last: 1'b1,
                             error: 1'b1};
              end
            end
          endcase
        end
      end
      trd_pkg::BK_PAT: pat_re = 1'b1;
      trd_pkg::BK_TRK: row_re = 1'b1;
      trd_pkg::BK_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          advance  = !is_last;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[cmd_i.addr[trd_pkg::PAT_AW-1:0]] <= cmd_i.value[15:0];
    end
    if (pat_re) begin
      pat_rdata_q <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[cmd_i.addr[trd_pkg::ROW_AW-1:0]] <= cmd_i.value;
    end
    if (row_re) begin
      row_rdata_q <= row_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pat_q   <= cmd_i.pat;
      row_q   <= cmd_i.row;
      chans_q <= chans_clamped;
    end
    if (row_re) begin
      blank_q <= blank;
    end
    if (load_out) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trd_pkg::BK_IDLE;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        chan_q <= '0;
      end else if (advance) begin
        chan_q <= chan_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = out_q;

endmodule

### design/tracker_row_decoder_top.sv
`timescale 1ns / 1ps
// Tracker row decoder. Write items load the pattern table (4096 x 16) and the
// track row store (16384 x 24); a read item decodes one row of one pattern
// into one result per active channel, the last one with tlast, or a single
// error result. Items pass a 4-entry command queue to the execute side. A
// write is stored in its table there; a read steps, for every active channel,
// through the pattern memory read, the track memory read and the decode into
// the output register, which waits while the output is stalled. No other item
// is taken from the queue during a read. Stores are undefined until written.
module tracker_row_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode, slot_address, write_value, row_number, pattern_number
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // channel, period, instrument, effect, effect_param
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // error
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_wdata_i
);

  trd_pkg::trd_cfg_t cfg_q;
  trd_pkg::trd_cmd_t front_cmd;
  trd_pkg::trd_cmd_t queue_cmd;
  trd_pkg::trd_res_t res;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count    <= 6'd4;
      cfg_q.rows_per_pattern <= 7'd64;
      cfg_q.last_pattern     <= 7'd0;
      cfg_q.track_count      <= 9'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trd_pkg::CFG_CHANNEL_COUNT:    cfg_q.channel_count    <= cfg_wdata_i[5:0];
        trd_pkg::CFG_ROWS_PER_PATTERN: cfg_q.rows_per_pattern <= cfg_wdata_i[6:0];
        trd_pkg::CFG_LAST_PATTERN:     cfg_q.last_pattern     <= cfg_wdata_i[6:0];
        trd_pkg::CFG_TRACK_COUNT:      cfg_q.track_count      <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  trd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cfg_i           (cfg_q),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  trd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_cmd)
  );

  trd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (empty),
    .cmd_i     (queue_cmd),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {2'b00, res.effect_param, res.effect, res.instrument,
                           res.period, res.channel};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.error;

endmodule

### dv/tracker_row_decoder_checker.sv
`timescale 1ns / 1ps
module tracker_row_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // opcode, slot_address, write_value, row_number, pattern_number
  input  logic [55:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // channel, period, instrument, effect, effect_param
  input  logic [39:0] m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  // error
  input  logic        m_axis_tuser_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  logic [15:0]        pat_mem [trd_pkg::PAT_DEPTH];
  logic [23:0]        row_mem [trd_pkg::ROW_DEPTH];
  logic [5:0]         chan_cnt;
  logic [6:0]         row_limit;
  logic [6:0]         top_pattern;
  logic [8:0]         trk_limit;
  trd_pkg::trd_res_t  decoded_q [$];
  int                 failures = 0;
  int                 checked = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
  end

  function automatic logic [14:0] period_of(input logic [5:0] note);
    logic [10:0] base;
    int          semi;
    int          oct;
    if (note == 6'd0) begin
      return '0;
    end
    semi = note % 12;
    oct  = note / 12;
    case (semi)
      0:       base = 11'd1712;
      1:       base = 11'd1616;
      2:       base = 11'd1524;
      3:       base = 11'd1440;
      4:       base = 11'd1356;
      5:       base = 11'd1280;
      6:       base = 11'd1208;
      7:       base = 11'd1140;
      8:       base = 11'd1076;
      9:       base = 11'd1016;
      10:      base = 11'd960;
      11:      base = 11'd907;
      default: base = 11'd0;
    endcase
    base = base >> oct;
    return {base, 4'b0000};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                checked, name, got, want));
    end
  endtask

  task automatic decode_request(input logic [5:0] row, input logic [7:0] pat);
    int                n;
    int                i;
    int unsigned       t;
    logic [15:0]       trk;
    logic [23:0]       bytes;
    trd_pkg::trd_res_t r;
    r = '0;
    if (row >= row_limit || pat > top_pattern || pat >= trd_pkg::MAX_PATTERNS ||
        row >= trd_pkg::TRACK_ROWS) begin
      r.last  = 1'b1;
      r.error = 1'b1;
      decoded_q.push_back(r);
      return;
    end
    n = (chan_cnt == 6'd0) ? 1 :
        ((chan_cnt > trd_pkg::CHANNELS) ? trd_pkg::CHANNELS : chan_cnt);
    for (i = 0; i < n; i++) begin
      trk = pat_mem[pat * trd_pkg::CHANNELS + i];
      bytes = '0;
      if (trk != 16'd0) begin
        t = trk - 16'd1;
        if (t < trk_limit && t < trd_pkg::MAX_TRACKS) begin
          bytes = row_mem[t * trd_pkg::TRACK_ROWS + row];
        end
      end
      r.channel      = i[4:0];
      r.period       = period_of(bytes[23:18]);
      r.instrument   = {bytes[17:16], bytes[15:12]};
      r.effect       = bytes[11:8];
      r.effect_param = bytes[7:0];
      r.last         = (i == n - 1);
      r.error        = 1'b0;
      decoded_q.push_back(r);
    end
  endtask

  task automatic take_item(input logic [55:0] d);
    logic [1:0]  op;
    logic [13:0] addr;
    logic [23:0] val;
    op   = d[1:0];
    addr = d[15:2];
    val  = d[39:16];
    case (op)
      trd_pkg::OP_PAT_WR: begin
        if (addr < trd_pkg::PAT_DEPTH) begin
          pat_mem[addr] = val[15:0];
        end
      end
      trd_pkg::OP_ROW_WR: begin
        if (addr < trd_pkg::ROW_DEPTH) begin
          row_mem[addr] = val;
        end
      end
      trd_pkg::OP_READ: begin
        decode_request(d[45:40], d[53:46]);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input logic [39:0] d, input logic last, input logic err);
    trd_pkg::trd_res_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
    end else begin
      want = decoded_q.pop_front();
      check_field("channel", d[4:0], want.channel);
      check_field("period", d[19:5], want.period);
      check_field("instrument", d[25:20], want.instrument);
      check_field("effect", d[29:26], want.effect);
      check_field("effect_param", d[37:30], want.effect_param);
      check_field("last", last, want.last);
      check_field("error", err, want.error);
    end
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt    = 6'd4;
      row_limit   = 7'd64;
      top_pattern = 7'd0;
      trk_limit   = 9'd0;
      decoded_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result(m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_item(s_axis_tdata_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          trd_pkg::CFG_CHANNEL_COUNT:    chan_cnt    = cfg_wdata_i[5:0];
          trd_pkg::CFG_ROWS_PER_PATTERN: row_limit   = cfg_wdata_i[6:0];
          trd_pkg::CFG_LAST_PATTERN:     top_pattern = cfg_wdata_i[6:0];
          trd_pkg::CFG_TRACK_COUNT:      trk_limit   = cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
    pending_o    <= decoded_q.size();
    fail_count_o <= failures;
    results_o    <= checked;
  end

endmodule

### dv/tb_tracker_row_decoder_top.sv
`timescale 1ns / 1ps
module tb_tracker_row_decoder_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEM_TARGET    = 250;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_wdata_i;

  int fail_count;
  int pending;
  int results;

  // what has been loaded so far, so that no read touches an unwritten entry
  logic [15:0] pat_track [trd_pkg::PAT_DEPTH];
  bit          pat_set [trd_pkg::PAT_DEPTH];
  bit          row_set [trd_pkg::ROW_DEPTH];
  logic [5:0]  cfg_chans;
  logic [6:0]  cfg_rows;
  logic [6:0]  cfg_last;
  logic [8:0]  cfg_tracks;

  bit send_calm;
  bit recv_calm;
  bit hold_req;
  int items_sent;
  int reads_sent;
  int bad_reads;
  int settings_used;
  int idle_cycles;

  tracker_row_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  tracker_row_decoder_checker row_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int gap;
    int served;
    served = 0;
    recv_calm = 1'b0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      served++;
      if (served % 16 == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      gap = recv_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  function automatic int active_chans();
    if (cfg_chans == 6'd0) begin
      return 1;
    end
    return (cfg_chans > trd_pkg::CHANNELS) ? trd_pkg::CHANNELS : cfg_chans;
  endfunction

  function automatic logic [15:0] pick_track();
    case ($urandom_range(0, 19))
      0, 1:    return 16'd0;
      2:       return $urandom_range(257, 65535);
      3:       return $urandom_range(1, 256);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [13:0] addr,
                           input logic [23:0] val, input logic [5:0] row,
                           input logic [7:0] pat);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (op == trd_pkg::OP_PAT_WR && addr < trd_pkg::PAT_DEPTH) begin
      pat_track[addr] = val[15:0];
      pat_set[addr]   = 1'b1;
    end
    if (op == trd_pkg::OP_ROW_WR) begin
      row_set[addr] = 1'b1;
    end
    if (op != OP_UNUSED) begin
      items_sent++;
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, pat, row, val, addr, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic write_pattern_slot(input int unsigned a);
    logic [23:0] val;
    val = $urandom;
    val[15:0] = pick_track();
    push_item(trd_pkg::OP_PAT_WR, a[13:0], val, $urandom, $urandom);
  endtask

  // loads whatever the request will look up, then sends it
  task automatic read_request(input logic [5:0] row, input logic [7:0] pat);
    int          n;
    int          i;
    int unsigned a;
    int unsigned t;
    logic [15:0] trk;
    if (row >= cfg_rows || pat > cfg_last || pat >= trd_pkg::MAX_PATTERNS) begin
      bad_reads++;
    end else begin
      n = active_chans();
      for (i = 0; i < n; i++) begin
        a = pat * trd_pkg::CHANNELS + i;
        if (!pat_set[a]) begin
          write_pattern_slot(a);
        end
        trk = pat_track[a];
        if (trk != 16'd0) begin
          t = trk - 16'd1;
          if (t < cfg_tracks && t < trd_pkg::MAX_TRACKS) begin
            t = t * trd_pkg::TRACK_ROWS + row;
            if (!row_set[t]) begin
              push_item(trd_pkg::OP_ROW_WR, t[13:0], $urandom, $urandom, $urandom);
            end
          end
        end
      end
    end
    reads_sent++;
    push_item(trd_pkg::OP_READ, $urandom, $urandom, row, pat);
  endtask

  task automatic set_config(input logic [8:0] chans, input logic [8:0] rows,
                            input logic [8:0] last, input logic [8:0] tracks);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= trd_pkg::CFG_CHANNEL_COUNT;
    cfg_wdata_i <= chans;
    @(posedge clk_i);
    cfg_index_i <= trd_pkg::CFG_ROWS_PER_PATTERN;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_index_i <= trd_pkg::CFG_LAST_PATTERN;
    cfg_wdata_i <= last;
    @(posedge clk_i);
    cfg_index_i <= trd_pkg::CFG_TRACK_COUNT;
    cfg_wdata_i <= tracks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_chans  = chans[5:0];
    cfg_rows   = rows[6:0];
    cfg_last   = last[6:0];
    cfg_tracks = tracks;
    settings_used++;
  endtask

  // wait for every result, then for queued writes to drain
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    int          stop;
    int          rows_ok;
    int          top;
    logic [5:0]  row;
    logic [7:0]  pat;
    logic [13:0] addr;
    logic [23:0] val;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 15) == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
      end
      rows_ok = (cfg_rows > 64) ? 64 : cfg_rows;
      top = (cfg_last < 3) ? cfg_last : 3;
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          addr = $urandom_range(0, 1) ? $urandom
                                      : $urandom_range(0, 4 * trd_pkg::CHANNELS - 1);
          val = $urandom;
          val[15:0] = pick_track();
          push_item(trd_pkg::OP_PAT_WR, addr, val, $urandom, $urandom);
        end
        3, 4, 5: begin
          addr = $urandom_range(0, 1) ? $urandom
                                      : $urandom_range(0, 6 * trd_pkg::TRACK_ROWS - 1);
          push_item(trd_pkg::OP_ROW_WR, addr, $urandom, $urandom, $urandom);
        end
        6: begin
          push_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
        7, 8: begin
          if (rows_ok < 64 && $urandom_range(0, 1)) begin
            row = $urandom_range(rows_ok, 63);
            pat = $urandom;
          end else begin
            row = $urandom;
            pat = $urandom_range(cfg_last + 1, 255);
          end
          read_request(row, pat);
        end
        default: begin
          if (rows_ok == 0) begin
            row = $urandom;
          end else begin
            row = $urandom_range(0, rows_ok - 1);
          end
          if ($urandom_range(0, 3) == 0) begin
            pat = $urandom_range(0, cfg_last);
          end else begin
            pat = $urandom_range(0, top);
          end
          read_request(row, pat);
        end
      endcase
    end
  endtask

  initial begin
    int k;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= trd_pkg::CFG_CHANNEL_COUNT;
    cfg_wdata_i     <= '0;
    idle_cycles     = 0;
    send_calm       = 1'b0;
    hold_req        = 1'b0;
    items_sent      = 0;
    reads_sent      = 0;
    bad_reads       = 0;
    settings_used   = 0;
    cfg_chans       = 6'd4;
    cfg_rows        = 7'd64;
    cfg_last        = 7'd0;
    cfg_tracks      = 9'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: table and row extremes, blank channels, bad requests
    set_config(9'd4, 9'd64, 9'd127, 9'd256);
    push_item(trd_pkg::OP_PAT_WR, 14'd0, 24'd1, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd1, 24'd0, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd2, 24'hFFFFFF, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd3, 24'd256, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd4064, 24'd2, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd4065, 24'd257, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd4066, 24'd1, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'd4067, 24'hA50001, 6'd0, 8'd0);
    push_item(trd_pkg::OP_PAT_WR, 14'h3FFF, 24'd5, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd0, 24'h041234, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd63, 24'hFFFFFF, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd5, 24'h2D5A3C, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd64, 24'h030000, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd69, 24'h30F00F, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'd16320, 24'h000000, 6'd0, 8'd0);
    push_item(trd_pkg::OP_ROW_WR, 14'h3FFF, 24'hF05AC3, 6'd0, 8'd0);
    push_item(OP_UNUSED, 14'h3FFF, 24'hFFFFFF, 6'd63, 8'd255);
    read_request(6'd0, 8'd0);
    read_request(6'd63, 8'd0);
    read_request(6'd0, 8'd127);
    read_request(6'd5, 8'd127);
    read_request(6'd63, 8'd128);
    read_request(6'd0, 8'd255);
    settle();

    // full rows while the result side holds off
    set_config(9'd32, 9'd64, 9'd3, 9'd256);
    hold_req = 1'b1;
    for (k = 0; k < 2; k++) begin
      read_request($urandom, $urandom_range(0, 3));
    end
    run_random(20);
    settle();

    set_config(9'd0, 9'd1, 9'd0, 9'd0);
    run_random(30);
    settle();

    set_config(9'd63, 9'd127, 9'd127, 9'd511);
    run_random(20);
    settle();

    set_config(9'd1, 9'd64, 9'd127, 9'd1);
    run_random(30);
    settle();

    while (items_sent < ITEM_TARGET) begin
      set_config($urandom, $urandom, $urandom, $urandom);
      run_random(40);
      settle();
    end
    repeat (100) @(posedge clk_i);

    $display("%0d items sent, %0d row reads (%0d out of range), %0d register settings",
             items_sent, reads_sent, bad_reads, settings_used);
    $display("%0d decoded results compared, %0d mismatches", results, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
